>>> rtl/hdlf_pkg.sv
// ----------------------------------------------------------------------------
// hdlf_pkg
// Shared constants, types and helpers of the hex dump line formatter.
// ----------------------------------------------------------------------------
package hdlf_pkg;

  localparam int unsigned GROUPS_PER_LINE = 4;
  localparam int unsigned GAP_SPACES      = 3;
  localparam int unsigned BYTES_PER_GROUP = 4;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_NL    = 8'h0a;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_A_OFS = 8'h57;  // 'a' - 10

  // Per-byte plan handed from the position stage to the emitter.
  typedef struct packed {
    logic [7:0] data;
    logic       gap;   // byte opens a group other than the first
    logic       mid;   // third byte of a group
    logic       nl;    // byte closes the line
    logic       eoi;   // end-of-input terminator
  } plan_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = CHAR_ZERO + {4'd0, nib};
    end else begin
      ch = CHAR_A_OFS + {4'd0, nib};
    end
    return ch;
  endfunction

endpackage

>>> rtl/hdlf_plan.sv
// ----------------------------------------------------------------------------
// hdlf_plan
// Input register and line position tracking; builds the plan of one beat.
// ----------------------------------------------------------------------------
module hdlf_plan #(
  parameter int unsigned GroupsPerLine = hdlf_pkg::GROUPS_PER_LINE
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  output logic                s_ready_o,
  input  logic [7:0]          s_byte_i,
  input  logic                s_eoi_i,
  output logic                plan_valid_o,
  input  logic                plan_ready_i,
  output hdlf_pkg::plan_t     plan_o
);

  localparam int unsigned LineBytes = GroupsPerLine * hdlf_pkg::BYTES_PER_GROUP;
  localparam int unsigned PosW      = $clog2(LineBytes);
  localparam logic [PosW-1:0] PosLast = PosW'(LineBytes - 1);

  logic            valid_q, valid_d;
  logic [7:0]      byte_q;
  logic            eoi_q;
  logic [PosW-1:0] pos_q, pos_d;
  logic            take;
  logic            load;

  assign take      = valid_q && plan_ready_i;
  assign s_ready_o = !valid_q || plan_ready_i;
  assign load      = s_valid_i && s_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take) begin
      valid_d = 1'b0;
    end
  end

  always_comb begin
    pos_d = pos_q;
    if (take) begin
      if (eoi_q || pos_q == PosLast) begin
        pos_d = '0;
      end else begin
        pos_d = pos_q + PosW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      pos_q   <= '0;
    end else begin
      valid_q <= valid_d;
      pos_q   <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= s_byte_i;
      eoi_q  <= s_eoi_i;
    end
  end

  assign plan_valid_o = valid_q;
  assign plan_o.data  = byte_q;
  assign plan_o.eoi   = eoi_q;
  assign plan_o.gap   = (pos_q[1:0] == 2'd0) && (pos_q != '0);
  assign plan_o.mid   = (pos_q[1:0] == 2'd2);
  assign plan_o.nl    = (pos_q == PosLast);

endmodule

>>> rtl/hdlf_emit.sv
// ----------------------------------------------------------------------------
// hdlf_emit
// Holds one plan and sends its characters, one per beat, through an
// output register.
// ----------------------------------------------------------------------------
module hdlf_emit #(
  parameter int unsigned GapSpaces = hdlf_pkg::GAP_SPACES
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            plan_valid_i,
  output logic            plan_ready_o,
  input  hdlf_pkg::plan_t plan_i,
  output logic            m_valid_o,
  input  logic            m_ready_i,
  output logic [7:0]      m_char_o,
  output logic            m_last_o
);

  localparam int unsigned SpMax = (GapSpaces > 1) ? GapSpaces : 1;
  localparam int unsigned SpW   = $clog2(SpMax + 1);

  logic           busy_q, busy_d;
  logic [SpW-1:0] sp_q, sp_d;
  logic           hi_q, hi_d;
  logic           lo_q, lo_d;
  logic           nl_q;
  logic           eoi_q;
  logic [7:0]     byte_q;
  logic           out_valid_q, out_valid_d;
  logic [7:0]     out_char_q;
  logic           out_last_q;

  logic           fire;
  logic           last_c;
  logic [7:0]     char_c;
  logic           load;

  assign fire   = busy_q && (!out_valid_q || m_ready_i);
  assign last_c = eoi_q || (sp_q == '0 && !hi_q && (!lo_q || !nl_q));
  assign plan_ready_o = !busy_q || (fire && last_c);
  assign load   = plan_valid_i && plan_ready_o;

  always_comb begin
    if (eoi_q) begin
      char_c = hdlf_pkg::CHAR_NUL;
    end else if (sp_q != '0) begin
      char_c = hdlf_pkg::CHAR_SPACE;
    end else if (hi_q) begin
      char_c = hdlf_pkg::hex_char(byte_q[7:4]);
    end else if (lo_q) begin
      char_c = hdlf_pkg::hex_char(byte_q[3:0]);
    end else begin
      char_c = hdlf_pkg::CHAR_NL;
    end
  end

  always_comb begin
    busy_d = busy_q;
    sp_d   = sp_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    if (fire) begin
      if (last_c) begin
        busy_d = 1'b0;
      end
      if (sp_q != '0) begin
        sp_d = sp_q - SpW'(1);
      end else if (hi_q) begin
        hi_d = 1'b0;
      end else begin
        lo_d = 1'b0;
      end
    end
    if (load) begin
      busy_d = 1'b1;
      hi_d   = 1'b1;
      lo_d   = 1'b1;
      if (plan_i.gap) begin
        sp_d = SpW'(GapSpaces);
      end else if (plan_i.mid) begin
        sp_d = SpW'(1);
      end else begin
        sp_d = '0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      sp_q        <= '0;
      hi_q        <= 1'b0;
      lo_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      sp_q        <= sp_d;
      hi_q        <= hi_d;
      lo_q        <= lo_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= plan_i.data;
      nl_q   <= plan_i.nl;
      eoi_q  <= plan_i.eoi;
    end
    if (fire) begin
      out_char_q <= char_c;
      out_last_q <= last_c;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_char_o  = out_char_q;
  assign m_last_o  = out_last_q;

endmodule

>>> rtl/hex_dump_line_formatter_unit.sv
// ----------------------------------------------------------------------------
// hex_dump_line_formatter_unit
// Formats a byte stream into hex dump text, one ASCII character per beat.
// ----------------------------------------------------------------------------
// Path: a byte passes the input register, the emitter's plan register and the output register.
// Throughput: one output character per cycle while m_axis_tready is high; a data byte
//   sends its spaces, two hex digits and, at line end, a newline; end of input one NUL.
// The input register takes the next byte while the current one is sent.
// Reset: asynchronous, active low; clears line position and all valid flags.
// ----------------------------------------------------------------------------
module hex_dump_line_formatter_unit #(
  parameter int unsigned GroupsPerLine = hdlf_pkg::GROUPS_PER_LINE,
  parameter int unsigned GapSpaces     = hdlf_pkg::GAP_SPACES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // end_of_input
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_char
  output logic       m_axis_tlast    // last
);

  logic            plan_valid;
  logic            plan_ready;
  hdlf_pkg::plan_t plan;

  hdlf_plan #(
    .GroupsPerLine(GroupsPerLine)
  ) u_plan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_byte_i    (s_axis_tdata),
    .s_eoi_i     (s_axis_tlast),
    .plan_valid_o(plan_valid),
    .plan_ready_i(plan_ready),
    .plan_o      (plan)
  );

  hdlf_emit #(
    .GapSpaces(GapSpaces)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .plan_valid_i(plan_valid),
    .plan_ready_o(plan_ready),
    .plan_i      (plan),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_char_o    (m_axis_tdata),
    .m_last_o    (m_axis_tlast)
  );

endmodule
